@@ sv/ulst_pkg.sv @@
// ----------------------------------------------------------------------------
// ulst_pkg
// Shared codes and types for the unsorted list table: opcodes, result
// status codes, controller-to-datapath actions and the command/flag structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ulst_pkg;

   localparam int CAPACITY_DEF  = 64;
   localparam int ITEM_BITS_DEF = 32;

   // request opcodes
   localparam logic [2:0] OP_PUT    = 3'd0;
   localparam logic [2:0] OP_GET    = 3'd1;
   localparam logic [2:0] OP_DEL    = 3'd2;
   localparam logic [2:0] OP_CURSOR = 3'd3;
   localparam logic [2:0] OP_NEXT   = 3'd4;
   localparam logic [2:0] OP_CLEAR  = 3'd5;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_NONEXT   = 2'd3;

   // datapath actions
   localparam int ACT_BITS = 4;
   localparam logic [ACT_BITS-1:0] ACT_NONE        = 4'd0;
   localparam logic [ACT_BITS-1:0] ACT_FULL        = 4'd1;
   localparam logic [ACT_BITS-1:0] ACT_PUT         = 4'd2;
   localparam logic [ACT_BITS-1:0] ACT_WALK_START  = 4'd3;
   localparam logic [ACT_BITS-1:0] ACT_WALK_ADV    = 4'd4;
   localparam logic [ACT_BITS-1:0] ACT_MISS        = 4'd5;
   localparam logic [ACT_BITS-1:0] ACT_GET_HIT     = 4'd6;
   localparam logic [ACT_BITS-1:0] ACT_DEL_HIT     = 4'd7;
   localparam logic [ACT_BITS-1:0] ACT_NEXT_START  = 4'd8;
   localparam logic [ACT_BITS-1:0] ACT_NEXT_FAIL   = 4'd9;
   localparam logic [ACT_BITS-1:0] ACT_NEXT_COMMIT = 4'd10;
   localparam logic [ACT_BITS-1:0] ACT_CLEAR       = 4'd11;
   localparam logic [ACT_BITS-1:0] ACT_ZERO        = 4'd12;
   localparam logic [ACT_BITS-1:0] ACT_EMIT        = 4'd13;

   typedef struct packed {
      logic                capture;
      logic                cursor_clear;
      logic [ACT_BITS-1:0] act;
   } ulst_cmd_type;

   typedef struct packed {
      logic full;
      logic head_ok;
      logic match;
      logic link_ok;
      logic cand_ok;
      logic out_busy;
   } ulst_flags_type;

endpackage

`default_nettype wire

@@ sv/unsorted_list_table.sv @@
// ----------------------------------------------------------------------------
// unsorted_list_table
// Bounded unsorted linked list of values with put, get, delete, cursor
// walk and clear; one result item per request item.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  req_opcode, req_item_value
//  rsp      out        rsp_valid/rsp_ready  rsp_status, rsp_item_out, rsp_found,
//                                           rsp_entry_count, rsp_has_next,
//                                           rsp_is_empty
//
//  A request is taken in idle, handled in an op state (two for a next that
//  finds an entry), then emitted. Get and delete walk up to CAPACITY entries:
//  the entry memories give one registered read per cycle, so the walk moves
//  one entry a cycle. A result waits in the output register while the next
//  item is taken; a new result stalls only if that register is still full.
//  Reset is immediate: no clearing pass, slot stores are tracked by counts.
// ----------------------------------------------------------------------------
`default_nettype none

module unsorted_list_table import ulst_pkg::*; #(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int ITEM_BITS = ITEM_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [2:0]                    req_opcode,
   input  wire logic [ITEM_BITS-1:0]          req_item_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic [ITEM_BITS-1:0]               rsp_item_out,
   output logic                               rsp_found,
   output logic [$clog2(CAPACITY+1)-1:0]      rsp_entry_count,
   output logic                               rsp_has_next,
   output logic                               rsp_is_empty
);

   ulst_cmd_type   cmd;
   ulst_flags_type flags;

   ulst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .flags      (flags),
      .cmd        (cmd)
   );

   ulst_dp #(
      .CAPACITY  (CAPACITY),
      .ITEM_BITS (ITEM_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .flags           (flags),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_item_out    (rsp_item_out),
      .rsp_found       (rsp_found),
      .rsp_entry_count (rsp_entry_count),
      .rsp_has_next    (rsp_has_next),
      .rsp_is_empty    (rsp_is_empty)
   );

endmodule

`default_nettype wire

@@ sv/ulst_ctrl.sv @@
// ----------------------------------------------------------------------------
// ulst_ctrl
// Sequencer for the unsorted list table. Decodes the opcode, steps the
// list walk and hands the finished item to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ulst_ctrl import ulst_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire logic [2:0]     req_opcode,
   input  wire ulst_flags_type flags,
   output ulst_cmd_type        cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_PUT  = 4'd1;
   localparam logic [3:0] S_GET  = 4'd2;
   localparam logic [3:0] S_DEL  = 4'd3;
   localparam logic [3:0] S_WGET = 4'd4;
   localparam logic [3:0] S_WDEL = 4'd5;
   localparam logic [3:0] S_CUR  = 4'd6;
   localparam logic [3:0] S_NXT0 = 4'd7;
   localparam logic [3:0] S_NXT1 = 4'd8;
   localparam logic [3:0] S_CLR  = 4'd9;
   localparam logic [3:0] S_NOP  = 4'd10;
   localparam logic [3:0] S_EMIT = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in         = state_ff;
      cmd.capture      = 1'b0;
      cmd.cursor_clear = 1'b0;
      cmd.act          = ACT_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (req_opcode)
                  OP_PUT:    state_in = S_PUT;
                  OP_GET:    state_in = S_GET;
                  OP_DEL:    state_in = S_DEL;
                  OP_CURSOR: state_in = S_CUR;
                  OP_NEXT:   state_in = S_NXT0;
                  OP_CLEAR:  state_in = S_CLR;
                  default:   state_in = S_NOP;
               endcase
            end
         end
         S_PUT: begin
            cmd.act  = flags.full ? ACT_FULL : ACT_PUT;
            state_in = S_EMIT;
         end
         S_GET, S_DEL: begin
            cmd.cursor_clear = (state_ff == S_DEL);
            if (flags.head_ok) begin
               cmd.act  = ACT_WALK_START;
               state_in = (state_ff == S_DEL) ? S_WDEL : S_WGET;
            end else begin
               cmd.act  = ACT_MISS;
               state_in = S_EMIT;
            end
         end
         S_WGET, S_WDEL: begin
            // one entry compared per cycle
            if (flags.match) begin
               cmd.act  = (state_ff == S_WDEL) ? ACT_DEL_HIT : ACT_GET_HIT;
               state_in = S_EMIT;
            end else if (flags.link_ok) begin
               cmd.act = ACT_WALK_ADV;
            end else begin
               cmd.act  = ACT_MISS;
               state_in = S_EMIT;
            end
         end
         S_CUR: begin
            cmd.cursor_clear = 1'b1;
            cmd.act          = ACT_ZERO;
            state_in         = S_EMIT;
         end
         S_NXT0: begin
            if (flags.cand_ok) begin
               cmd.act  = ACT_NEXT_START;
               state_in = S_NXT1;
            end else begin
               cmd.act  = ACT_NEXT_FAIL;
               state_in = S_EMIT;
            end
         end
         S_NXT1: begin
            cmd.act  = ACT_NEXT_COMMIT;
            state_in = S_EMIT;
         end
         S_CLR: begin
            cmd.act  = ACT_CLEAR;
            state_in = S_EMIT;
         end
         S_NOP: begin
            cmd.act  = ACT_ZERO;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!flags.out_busy) begin
               cmd.act  = ACT_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/ulst_dp.sv @@
// ----------------------------------------------------------------------------
// ulst_dp
// Datapath of the unsorted list table: entry value and link memories, the
// stack of recycled slots, head and cursor, result staging and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ulst_dp import ulst_pkg::*; #(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int ITEM_BITS = ITEM_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ulst_cmd_type                  cmd,
   output ulst_flags_type                     flags,
   input  wire logic [ITEM_BITS-1:0]          req_item_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic [ITEM_BITS-1:0]               rsp_item_out,
   output logic                               rsp_found,
   output logic [$clog2(CAPACITY+1)-1:0]      rsp_entry_count,
   output logic                               rsp_has_next,
   output logic                               rsp_is_empty
);

   localparam int ADDR_BITS  = $clog2(CAPACITY);
   localparam int COUNT_BITS = $clog2(CAPACITY+1);
   localparam int LINK_BITS  = ADDR_BITS + 1;   // msb set: slot is valid
   localparam logic [LINK_BITS-1:0] NONE_LINK = '0;

   logic [ITEM_BITS-1:0] val_mem  [CAPACITY];
   logic [LINK_BITS-1:0] link_mem [CAPACITY];
   logic [ADDR_BITS-1:0] free_mem [CAPACITY];

   logic [ITEM_BITS-1:0]  val_q_ff;
   logic [LINK_BITS-1:0]  link_q_ff;
   logic [ADDR_BITS-1:0]  free_q_ff;

   logic [ITEM_BITS-1:0]  item_ff,        item_in;
   logic [LINK_BITS-1:0]  head_ff,        head_in;
   logic [LINK_BITS-1:0]  cursor_ff,      cursor_in;
   logic [LINK_BITS-1:0]  cursor_next_ff, cursor_next_in;
   logic [LINK_BITS-1:0]  prev_ff,        prev_in;
   logic [ADDR_BITS-1:0]  cur_ff,         cur_in;
   logic [COUNT_BITS-1:0] count_ff,       count_in;
   logic [COUNT_BITS-1:0] sp_ff,          sp_in;
   logic [COUNT_BITS-1:0] fresh_ff,       fresh_in;   // slots never handed out start here

   logic [1:0]            st_status_ff,   st_status_in;
   logic [ITEM_BITS-1:0]  st_item_ff,     st_item_in;
   logic                  st_found_ff,    st_found_in;

   logic                  rsp_valid_ff,   rsp_valid_in;
   logic [1:0]            rsp_status_ff,  rsp_status_in;
   logic [ITEM_BITS-1:0]  rsp_item_ff,    rsp_item_in;
   logic                  rsp_found_ff,   rsp_found_in;
   logic [COUNT_BITS-1:0] rsp_count_ff,   rsp_count_in;
   logic                  rsp_hn_ff,      rsp_hn_in;
   logic                  rsp_empty_ff,   rsp_empty_in;

   logic [LINK_BITS-1:0]  cand;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [COUNT_BITS-1:0] sp_dec;
   logic [ADDR_BITS-1:0]  pop_slot;

   // next entry for a step of the cursor
   assign cand     = cursor_ff[ADDR_BITS] ? cursor_next_ff : head_ff;
   assign sp_dec   = sp_ff - COUNT_BITS'(1);
   assign pop_slot = (sp_ff != '0) ? free_q_ff : fresh_ff[ADDR_BITS-1:0];

   assign flags.full     = (count_ff == COUNT_BITS'(CAPACITY));
   assign flags.head_ok  = head_ff[ADDR_BITS];
   assign flags.match    = (val_q_ff == item_ff);
   assign flags.link_ok  = link_q_ff[ADDR_BITS];
   assign flags.cand_ok  = cand[ADDR_BITS];
   assign flags.out_busy = rsp_valid_ff & ~rsp_ready;

   always_comb begin
      unique case (cmd.act)
         ACT_WALK_START: rd_addr = head_ff[ADDR_BITS-1:0];
         ACT_WALK_ADV:   rd_addr = link_q_ff[ADDR_BITS-1:0];
         ACT_NEXT_START: rd_addr = cand[ADDR_BITS-1:0];
         default:        rd_addr = cur_ff;
      endcase
   end

   // memories: one write address and one registered read per array
   always_ff @(posedge clock) begin
      val_q_ff  <= val_mem[rd_addr];
      link_q_ff <= link_mem[rd_addr];
      free_q_ff <= free_mem[sp_dec[ADDR_BITS-1:0]];
      if (cmd.act == ACT_PUT) begin
         val_mem[pop_slot]  <= item_ff;
         link_mem[pop_slot] <= head_ff;
      end
      if (cmd.act == ACT_DEL_HIT) begin
         if (prev_ff[ADDR_BITS]) begin
            link_mem[prev_ff[ADDR_BITS-1:0]] <= link_q_ff;
         end
         free_mem[sp_ff[ADDR_BITS-1:0]] <= cur_ff;
      end
   end

   always_comb begin
      item_in        = cmd.capture ? req_item_value : item_ff;
      head_in        = head_ff;
      cursor_in      = cmd.cursor_clear ? NONE_LINK : cursor_ff;
      cursor_next_in = cursor_next_ff;
      prev_in        = prev_ff;
      cur_in         = cur_ff;
      count_in       = count_ff;
      sp_in          = sp_ff;
      fresh_in       = fresh_ff;
      st_status_in   = st_status_ff;
      st_item_in     = st_item_ff;
      st_found_in    = st_found_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_item_in    = rsp_item_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_hn_in      = rsp_hn_ff;
      rsp_empty_in   = rsp_empty_ff;

      unique case (cmd.act)
         ACT_FULL: begin
            st_status_in = ST_FULL;
            st_item_in   = item_ff;
            st_found_in  = 1'b0;
         end
         ACT_PUT: begin
            head_in  = {1'b1, pop_slot};
            count_in = count_ff + COUNT_BITS'(1);
            if (sp_ff != '0) begin
               sp_in = sp_dec;
            end else begin
               fresh_in = fresh_ff + COUNT_BITS'(1);
            end
            st_status_in = ST_OK;
            st_item_in   = item_ff;
            st_found_in  = 1'b0;
         end
         ACT_WALK_START: begin
            cur_in  = head_ff[ADDR_BITS-1:0];
            prev_in = NONE_LINK;
         end
         ACT_WALK_ADV: begin
            prev_in = {1'b1, cur_ff};
            cur_in  = link_q_ff[ADDR_BITS-1:0];
         end
         ACT_MISS: begin
            st_status_in = ST_NOTFOUND;
            st_item_in   = item_ff;
            st_found_in  = 1'b0;
         end
         ACT_GET_HIT: begin
            st_status_in = ST_OK;
            st_item_in   = val_q_ff;
            st_found_in  = 1'b1;
         end
         ACT_DEL_HIT: begin
            // unlinking the head moves the head; otherwise prev is relinked in memory
            if (!prev_ff[ADDR_BITS]) begin
               head_in = link_q_ff;
            end
            count_in     = count_ff - COUNT_BITS'(1);
            sp_in        = sp_ff + COUNT_BITS'(1);
            st_status_in = ST_OK;
            st_item_in   = item_ff;
            st_found_in  = 1'b1;
         end
         ACT_NEXT_START: begin
            cur_in = cand[ADDR_BITS-1:0];
         end
         ACT_NEXT_FAIL: begin
            st_status_in = ST_NONEXT;
            st_item_in   = '0;
            st_found_in  = 1'b0;
         end
         ACT_NEXT_COMMIT: begin
            cursor_in      = {1'b1, cur_ff};
            cursor_next_in = link_q_ff;
            st_status_in   = ST_OK;
            st_item_in     = val_q_ff;
            st_found_in    = 1'b0;
         end
         ACT_CLEAR: begin
            head_in      = NONE_LINK;
            cursor_in    = NONE_LINK;
            count_in     = '0;
            sp_in        = '0;
            fresh_in     = '0;
            st_status_in = ST_OK;
            st_item_in   = '0;
            st_found_in  = 1'b0;
         end
         ACT_ZERO: begin
            st_status_in = ST_OK;
            st_item_in   = '0;
            st_found_in  = 1'b0;
         end
         ACT_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = st_status_ff;
            rsp_item_in   = st_item_ff;
            rsp_found_in  = st_found_ff;
            rsp_count_in  = count_ff;
            rsp_hn_in     = cursor_ff[ADDR_BITS] ? cursor_next_ff[ADDR_BITS]
                                                 : head_ff[ADDR_BITS];
            rsp_empty_in  = (count_ff == '0);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= NONE_LINK;
         cursor_ff    <= NONE_LINK;
         count_ff     <= '0;
         sp_ff        <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         cursor_ff    <= cursor_in;
         count_ff     <= count_in;
         sp_ff        <= sp_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      cursor_next_ff <= cursor_next_in;
      prev_ff        <= prev_in;
      cur_ff         <= cur_in;
      st_status_ff   <= st_status_in;
      st_item_ff     <= st_item_in;
      st_found_ff    <= st_found_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_item_ff    <= rsp_item_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_hn_ff      <= rsp_hn_in;
      rsp_empty_ff   <= rsp_empty_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_item_out    = rsp_item_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_has_next    = rsp_hn_ff;
   assign rsp_is_empty    = rsp_empty_ff;

endmodule

`default_nettype wire

@@ sv/ulst_check.sv @@
// ----------------------------------------------------------------------------
// ulst_check
// Port-level checks for the unsorted list table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ulst_check import ulst_pkg::*; #(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int ITEM_BITS = ITEM_BITS_DEF
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic [2:0]                    req_opcode,
   input wire logic [ITEM_BITS-1:0]          req_item_value,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [1:0]                    rsp_status,
   input wire logic [ITEM_BITS-1:0]          rsp_item_out,
   input wire logic                          rsp_found,
   input wire logic [$clog2(CAPACITY+1)-1:0] rsp_entry_count,
   input wire logic                          rsp_has_next,
   input wire logic                          rsp_is_empty
);

   localparam int COUNT_BITS = $clog2(CAPACITY+1);

   // a waiting request item holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_opcode)
         && $stable(req_item_value))
      else $error("request item changed while waiting");

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_item_out) && $stable(rsp_entry_count))
      else $error("result item changed while stalled");

   // empty flag agrees with the count, and an empty list has nothing to walk
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0))
         && !(rsp_is_empty && rsp_has_next))
      else $error("empty flag inconsistent");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |->
         rsp_entry_count == COUNT_BITS'(CAPACITY) && !rsp_found)
      else $error("full reported below capacity");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == ST_OK)
      else $error("found with failing status");

endmodule

bind unsorted_list_table ulst_check #(
   .CAPACITY  (CAPACITY),
   .ITEM_BITS (ITEM_BITS)
) u_ulst_check (.*);

`default_nettype wire
